// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the lock table RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BRL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BRL_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRL_ASSERT(lbl, clk, rst, prop, msg)
`define BRL_ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/brl_pkg.sv -----
// Types and constants for the byte-range lock table.
// No dependencies; used by every module of the block.
`default_nettype none
package brl_pkg;
  localparam int MaxLocksDefault = 16;
  localparam int LheldW = 5;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_PURGE = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] TYPE_READ   = 2'd0;
  localparam logic [1:0] TYPE_WRITE  = 2'd1;
  localparam logic [1:0] TYPE_UNLOCK = 2'd2;
  localparam logic [1:0] TYPE_BAD    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [63:0] U64_MAX = '1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  lock_type;
    logic [63:0] session;
    logic [63:0] owner;
    logic [63:0] range_start;
    logic [63:0] range_length;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        found_type;
    logic [63:0]       found_session;
    logic [63:0]       found_owner;
    logic [63:0]       found_start;
    logic [63:0]       found_length;
    logic [LheldW-1:0] locks_held;
  } res_t;

  typedef struct packed {
    logic [1:0]  ltype;
    logic [63:0] session;
    logic [63:0] owner;
    logic [63:0] start;
    logic [63:0] length;
  } lock_t;

  typedef struct packed {
    logic       conflict;
    logic [1:0] cnt;
  } unit_st_t;

  function automatic logic [63:0] end_of(input logic [63:0] s, input logic [63:0] l);
    return (l == 64'd0) ? U64_MAX : s + l;
  endfunction

  function automatic logic [63:0] enc_len(input logic [63:0] s, input logic [63:0] e);
    return (e == U64_MAX) ? 64'd0 : e - s;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/brl_mem.sv -----
// Single write port, single registered read port lock memory.
// Depends on brl_pkg for the lock entry type.
`default_nettype none
module brl_mem #(
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire brl_pkg::lock_t  wdata,
  input  wire logic [AW-1:0]   raddr,
  output brl_pkg::lock_t       rdata
);
  import brl_pkg::*;

  lock_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/brl_unit.sv -----
// Shared compare unit: conflict test and split/merge of one held entry
// against the proposed range. Depends on brl_pkg.
`default_nettype none
module brl_unit (
  input  wire brl_pkg::lock_t    e,
  input  wire brl_pkg::lock_t    p,
  output brl_pkg::unit_st_t      st,
  output brl_pkg::lock_t         o0,
  output brl_pkg::lock_t         o1,
  output brl_pkg::lock_t         np
);
  import brl_pkg::*;

  logic [63:0] es, ps, ee, pe;
  logic        same, differ;

  always_comb begin
    es = e.start;
    ps = p.start;
    ee = end_of(es, e.length);
    pe = end_of(ps, p.length);
    same = (e.session == p.session) && (e.owner == p.owner);
    differ = e.ltype != p.ltype;

    st.conflict = !((e.ltype == TYPE_READ) && (p.ltype == TYPE_READ)) && !same &&
                  !((es >= pe) || (ps >= ee));

    o0 = e;
    o1 = e;
    np = p;
    st.cnt = 2'd0;
    if (!same || es > pe || ps > ee) begin
      st.cnt = 2'd1;
    end else if (es >= ps && ee <= pe) begin
      st.cnt = 2'd0;
    end else if (pe == es) begin
      if (differ) st.cnt = 2'd1;
      else np.length = enc_len(ps, ee);
    end else if (ee == ps) begin
      if (differ) st.cnt = 2'd1;
      else begin
        np.start = es;
        np.length = enc_len(es, pe);
      end
    end else if (es >= ps && es <= pe && ee > pe) begin
      if (differ) begin
        o0.start = pe;
        o0.length = enc_len(pe, ee);
        st.cnt = 2'd1;
      end else np.length = enc_len(ps, ee);
    end else if (es < ps && ee >= ps && ee <= pe) begin
      if (differ) begin
        o0.length = enc_len(es, ps);
        st.cnt = 2'd1;
      end else begin
        np.start = es;
        np.length = enc_len(es, pe);
      end
    end else if (es < ps && ee > pe) begin
      if (differ) begin
        o0.length = enc_len(es, ps);
        o1.start = pe;
        o1.length = enc_len(pe, ee);
        st.cnt = 2'd2;
      end else begin
        np.start = es;
        np.length = e.length;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/byte_range_lock_table.sv -----
// Byte-range lock table top level: request sequencer over the lock memory,
// a scratch memory and the shared compare unit. Depends on brl_pkg, brl_mem, brl_unit.
//
// Usage: present a request on 'request' and raise 'start' while 'busy' is low;
// the transaction is taken at that edge and busy rises the next cycle.
// Kinds: set (read, write or unlock), get first conflicting lock, purge session.
// One result appears on 'result' with 'done' high for exactly one cycle;
// the receiver cannot stall it and must take it then. busy falls after done.
// Sequence: the sequencer walks the table entry by entry (memory read in S_RD,
// then compare/merge in the shared unit in S_EV), with an extra S_EV2 step when
// an entry splits in two. A set then copies the scratch list back (S_CRD read,
// S_CWR write per piece) and inserts the new lock in order; an invalid request
// goes straight to S_DONE.
// One transaction is in flight at a time.
// Reset (synchronous, rst high) empties the table; memory contents are not
// cleared, only the entry count.
`default_nettype none
`include "assert_macros.svh"
module byte_range_lock_table #(
  parameter int MAX_LOCKS = brl_pkg::MaxLocksDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire brl_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output brl_pkg::res_t      result
);
  import brl_pkg::*;

  localparam int CW  = $clog2(MAX_LOCKS + 1);
  localparam int IW  = $clog2(MAX_LOCKS);
  localparam int SD  = 2 * MAX_LOCKS;
  localparam int SW  = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_EV   = 7'b0000100,
    S_EV2  = 7'b0001000,
    S_CRD  = 7'b0010000,
    S_CWR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [1:0]  kind, kind_next;
  lock_t       req, req_next;
  lock_t       p, p_next;
  lock_t       found, found_next;
  lock_t       o1_hold, o1_hold_next;
  logic [1:0]  status, status_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] w, w_next;
  logic [SW-1:0] n, n_next;
  logic [SW-1:0] k, k_next;
  logic        ins, ins_next;

  logic        t_we, s_we;
  logic [IW-1:0] t_waddr;
  logic [SIW-1:0] s_waddr;
  lock_t       t_wdata, s_wdata, t_rdata, s_rdata;
  unit_st_t    ust;
  lock_t       u_o0, u_o1, u_np;
  logic [64:0] range_sum;
  logic        unlock;

  brl_mem #(.DEPTH(MAX_LOCKS)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(idx[IW-1:0]), .rdata(t_rdata)
  );

  brl_mem #(.DEPTH(SD)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(k[SIW-1:0]), .rdata(s_rdata)
  );

  brl_unit u_unit (
    .e(t_rdata), .p(p), .st(ust), .o0(u_o0), .o1(u_o1), .np(u_np)
  );

  assign unlock = req.ltype == TYPE_UNLOCK;
  assign range_sum = {1'b0, request.range_start} + {1'b0, request.range_length};

  always_comb begin
    state_next = state;
    kind_next = kind;
    req_next = req;
    p_next = p;
    found_next = found;
    o1_hold_next = o1_hold;
    status_next = status;
    count_next = count;
    idx_next = idx;
    w_next = w;
    n_next = n;
    k_next = k;
    ins_next = ins;
    t_we = 1'b0;
    t_waddr = w[IW-1:0];
    t_wdata = t_rdata;
    s_we = 1'b0;
    s_waddr = n[SIW-1:0];
    s_wdata = u_o0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          kind_next = request.kind;
          req_next = '{request.lock_type, request.session, request.owner,
                       request.range_start, request.range_length};
          p_next = req_next;
          found_next = req_next;
          found_next.ltype = TYPE_UNLOCK;
          status_next = ST_OK;
          idx_next = '0;
          w_next = '0;
          n_next = '0;
          if (request.kind == KIND_PURGE) begin
            state_next = S_RD;
          end else if (request.kind == KIND_BAD || request.lock_type == TYPE_BAD ||
                       range_sum[64]) begin
            status_next = ST_INVALID;
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx == count) begin
          case (kind)
            KIND_PURGE: begin
              count_next = w;
              state_next = S_DONE;
            end
            KIND_GET: state_next = S_DONE;
            default: begin
              k_next = '0;
              w_next = '0;
              ins_next = unlock;
              if (unlock ? (n > SW'(MAX_LOCKS)) : (n >= SW'(MAX_LOCKS))) begin
                status_next = ST_FULL;
                state_next = S_DONE;
              end else begin
                state_next = S_CRD;
              end
            end
          endcase
        end else begin
          state_next = S_EV;
        end
      end
      S_EV: begin
        idx_next = idx + 1'b1;
        state_next = S_RD;
        case (kind)
          KIND_PURGE: begin
            if (t_rdata.session != req.session) begin
              t_we = 1'b1;
              w_next = w + 1'b1;
            end
          end
          KIND_GET: begin
            if (ust.conflict) begin
              found_next = t_rdata;
              state_next = S_DONE;
            end
          end
          default: begin
            if (!unlock && ust.conflict) begin
              status_next = ST_CONFLICT;
              state_next = S_DONE;
            end else begin
              p_next = u_np;
              s_we = ust.cnt != 2'd0;
              n_next = n + SW'(ust.cnt);
              o1_hold_next = u_o1;
              if (ust.cnt == 2'd2) state_next = S_EV2;
            end
          end
        endcase
      end
      S_EV2: begin
        s_we = 1'b1;
        s_waddr = SIW'(n - 1'b1);
        s_wdata = o1_hold;
        state_next = S_RD;
      end
      S_CRD: begin
        if (k == n) begin
          if (!ins) begin
            t_we = 1'b1;
            t_wdata = p;
          end
          count_next = w + CW'(!ins);
          state_next = S_DONE;
        end else begin
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        t_we = 1'b1;
        w_next = w + 1'b1;
        if (!ins && s_rdata.start > p.start) begin
          t_wdata = p;
          ins_next = 1'b1;
        end else begin
          t_wdata = s_rdata;
          k_next = k + 1'b1;
          state_next = S_CRD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    t_wdata.ltype = {1'b0, t_wdata.ltype[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      n <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      n <= n_next;
    end
    kind <= kind_next;
    req <= req_next;
    p <= p_next;
    found <= found_next;
    o1_hold <= o1_hold_next;
    status <= status_next;
    idx <= idx_next;
    w <= w_next;
    k <= k_next;
    ins <= ins_next;
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;
  assign result = '{status, found.ltype, found.session, found.owner, found.start,
                    found.length, LheldW'(count)};

  `BRL_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accept did not start work")
  `BRL_ASSERT(a_done_idle, clk, rst, done |=> !busy, "busy after result")
  `BRL_ASSERT(a_count_max, clk, rst, count <= CW'(MAX_LOCKS), "table count over capacity")
  `BRL_ASSERT(a_scratch_max, clk, rst, n <= SW'(SD), "scratch list overflow")
endmodule
`default_nettype wire

// ----- verif/byte_range_lock_table_tb.sv -----
// Self-checking testbench for byte_range_lock_table: directed and random lock requests,
// with results checked against a built-in table model. Depends on brl_pkg and the RTL.
`default_nettype none
module byte_range_lock_table_tb;
  import brl_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy, done;
  res_t result;

  byte_range_lock_table DUT (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t pending_reqs[$];
  res_t expected_results[$];
  lock_t held[Depth];
  int held_cnt = 0;
  int errors = 0;
  int cycles = 0;
  int n_ok = 0, n_conflict = 0, n_invalid = 0, n_full = 0;
  bit calm = 1'b0;

  // ---------------- table model ----------------
  function automatic logic [63:0] stop_at(logic [63:0] s, logic [63:0] l);
    return (l == 64'd0) ? '1 : s + l;
  endfunction

  function automatic logic [63:0] span_len(logic [63:0] s, logic [63:0] e);
    return (e == '1) ? 64'd0 : e - s;
  endfunction

  function automatic bit same_holder(lock_t a, lock_t b);
    return a.session == b.session && a.owner == b.owner;
  endfunction

  function automatic bit clashes(lock_t a, lock_t b);
    if (a.ltype == TYPE_READ && b.ltype == TYPE_READ) return 1'b0;
    if (same_holder(a, b)) return 1'b0;
    return !(a.start >= stop_at(b.start, b.length) || b.start >= stop_at(a.start, a.length));
  endfunction

  // Combine held lock e with proposed range p; returns the number of surviving pieces of e (in o0, o1).
  function automatic int merge_piece(lock_t e, inout lock_t p, output lock_t o0,
                                     output lock_t o1);
    logic [63:0] es, ps, ee, pe;
    bit differ;
    es = e.start; ps = p.start;
    ee = stop_at(es, e.length); pe = stop_at(ps, p.length);
    differ = e.ltype != p.ltype;
    o0 = e; o1 = e;
    if (!same_holder(e, p) || es > pe || ps > ee) return 1;
    if (es >= ps && ee <= pe) return 0;
    if (pe == es) begin
      if (differ) return 1;
      p.length = span_len(ps, ee);
      return 0;
    end
    if (ee == ps) begin
      if (differ) return 1;
      p.start = es; p.length = span_len(es, pe);
      return 0;
    end
    if (es >= ps && es <= pe && ee > pe) begin
      if (differ) begin
        o0.start = pe; o0.length = span_len(pe, ee);
        return 1;
      end
      p.length = span_len(ps, ee);
      return 0;
    end
    if (es < ps && ee >= ps && ee <= pe) begin
      if (differ) begin
        o0.length = span_len(es, ps);
        return 1;
      end
      p.start = es; p.length = span_len(es, pe);
      return 0;
    end
    if (es < ps && ee > pe) begin
      if (differ) begin
        o0.length = span_len(es, ps);
        o1.start = pe; o1.length = span_len(pe, ee);
        return 2;
      end
      p.start = es; p.length = e.length;
      return 0;
    end
    return 0;
  endfunction

  function automatic logic [1:0] apply_set(lock_t r);
    lock_t pieces[2*Depth+2];
    lock_t p, a, b;
    int n, k, pos;
    bit unlock;
    p = r; n = 0;
    unlock = r.ltype == TYPE_UNLOCK;
    for (int i = 0; i < held_cnt; i++) begin
      if (!unlock && clashes(held[i], p)) return ST_CONFLICT;
      k = merge_piece(held[i], p, a, b);
      if (k > 0) pieces[n] = a;
      if (k > 1) pieces[n+1] = b;
      n += k;
    end
    if (!unlock) begin
      pos = n;
      for (int i = 0; i < n; i++)
        if (pieces[i].start > p.start) begin
          pos = i;
          break;
        end
      if (n + 1 > Depth) return ST_FULL;
      for (int i = n; i > pos; i--) pieces[i] = pieces[i-1];
      pieces[pos] = p;
      n++;
    end else if (n > Depth) begin
      return ST_FULL;
    end
    for (int i = 0; i < n; i++) begin
      held[i] = pieces[i];
      held[i].ltype = {1'b0, pieces[i].ltype[0]};
    end
    held_cnt = n;
    return ST_OK;
  endfunction

  function automatic res_t predict_lock_op(req_t q);
    res_t r;
    lock_t want;
    int k;
    want = '{ltype: q.lock_type, session: q.session, owner: q.owner,
             start: q.range_start, length: q.range_length};
    r.status = ST_OK;
    r.found_type = TYPE_UNLOCK;
    r.found_session = q.session; r.found_owner = q.owner;
    r.found_start = q.range_start; r.found_length = q.range_length;
    if (q.kind == KIND_PURGE) begin
      k = 0;
      for (int i = 0; i < held_cnt; i++)
        if (held[i].session != q.session) begin
          held[k] = held[i];
          k++;
        end
      held_cnt = k;
    end else if (q.kind == KIND_BAD || q.lock_type == TYPE_BAD ||
                 q.range_length > ~q.range_start) begin
      r.status = ST_INVALID;
    end else if (q.kind == KIND_GET) begin
      for (int i = 0; i < held_cnt; i++)
        if (clashes(held[i], want)) begin
          r.found_type = held[i].ltype;
          r.found_session = held[i].session; r.found_owner = held[i].owner;
          r.found_start = held[i].start; r.found_length = held[i].length;
          break;
        end
    end else begin
      r.status = apply_set(want);
    end
    r.locks_held = held_cnt[LheldW-1:0];
    return r;
  endfunction

  // ---------------- driver ----------------
  int idle_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      if (start && !busy)
        expected_results.push_back(predict_lock_op(request));
      if (start && busy) begin
        // hold the current transaction
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 3);
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        case (e.status)
          ST_OK: n_ok++;
          ST_CONFLICT: n_conflict++;
          ST_INVALID: n_invalid++;
          default: n_full++;
        endcase
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); errors++;
        end
        if (result.found_type !== e.found_type) begin
          $error("found_type exp %0d got %0d", e.found_type, result.found_type); errors++;
        end
        if (result.found_session !== e.found_session) begin
          $error("found_session exp %h got %h", e.found_session, result.found_session);
          errors++;
        end
        if (result.found_owner !== e.found_owner) begin
          $error("found_owner exp %h got %h", e.found_owner, result.found_owner); errors++;
        end
        if (result.found_start !== e.found_start) begin
          $error("found_start exp %h got %h", e.found_start, result.found_start); errors++;
        end
        if (result.found_length !== e.found_length) begin
          $error("found_length exp %h got %h", e.found_length, result.found_length);
          errors++;
        end
        if (result.locks_held !== e.locks_held) begin
          $error("locks_held exp %0d got %0d", e.locks_held, result.locks_held); errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t mk(logic [1:0] k, logic [1:0] t, logic [63:0] s, logic [63:0] o,
                              logic [63:0] st, logic [63:0] l);
    req_t q;
    q.kind = k; q.lock_type = t; q.session = s; q.owner = o;
    q.range_start = st; q.range_length = l;
    return q;
  endfunction

  function automatic req_t random_req();
    req_t q;
    int sel;
    sel = $urandom_range(0, 99);
    q.kind = sel < 68 ? KIND_SET : sel < 88 ? KIND_GET : sel < 98 ? KIND_PURGE : KIND_BAD;
    sel = $urandom_range(0, 99);
    q.lock_type = sel < 40 ? TYPE_READ : sel < 75 ? TYPE_WRITE : sel < 98 ? TYPE_UNLOCK
                  : TYPE_BAD;
    q.session = $urandom_range(0, 19) == 0 ? rand64() : 64'($urandom_range(0, 3));
    q.owner = $urandom_range(0, 19) == 0 ? rand64() : 64'($urandom_range(0, 2));
    sel = $urandom_range(0, 99);
    if (sel < 85) q.range_start = 64'($urandom_range(0, 80));
    else if (sel < 95) q.range_start = ~64'($urandom_range(0, 40));
    else q.range_start = rand64();
    sel = $urandom_range(0, 99);
    if (sel < 15) q.range_length = 64'd0;
    else if (sel < 93) q.range_length = 64'($urandom_range(1, 24));
    else q.range_length = rand64();
    return q;
  endfunction

  localparam logic [63:0] AllOnes = '1;
  initial begin
    // directed part
    pending_reqs.push_back(mk(KIND_GET, TYPE_WRITE, 1, 1, 0, 0));
    pending_reqs.push_back(mk(KIND_SET, TYPE_UNLOCK, 1, 1, 0, 10));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 1, 1, 10, 10));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 1, 1, 20, 5));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 1, 1, 5, 5));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 2, 7, 0, 30));
    pending_reqs.push_back(mk(KIND_SET, TYPE_WRITE, 3, 1, 12, 2));
    pending_reqs.push_back(mk(KIND_GET, TYPE_WRITE, 3, 1, 12, 2));
    pending_reqs.push_back(mk(KIND_GET, TYPE_UNLOCK, 3, 1, 0, 0));
    pending_reqs.push_back(mk(KIND_GET, TYPE_READ, 3, 1, 0, 0));
    pending_reqs.push_back(mk(KIND_SET, TYPE_WRITE, 1, 1, 12, 3));
    pending_reqs.push_back(mk(KIND_SET, TYPE_UNLOCK, 1, 1, 6, 2));
    pending_reqs.push_back(mk(KIND_SET, TYPE_WRITE, 4, 4, 100, 0));
    pending_reqs.push_back(mk(KIND_SET, TYPE_UNLOCK, 4, 4, 200, 10));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 4, 4, AllOnes, 0));
    pending_reqs.push_back(mk(KIND_SET, TYPE_READ, 4, 4, AllOnes, 1));
    pending_reqs.push_back(mk(KIND_GET, TYPE_READ, 4, 4, 1, AllOnes));
    pending_reqs.push_back(mk(KIND_BAD, TYPE_READ, 1, 1, 0, 1));
    pending_reqs.push_back(mk(KIND_SET, TYPE_BAD, 1, 1, 0, 1));
    pending_reqs.push_back(mk(KIND_GET, TYPE_BAD, AllOnes, AllOnes, 0, 1));
    pending_reqs.push_back(mk(KIND_PURGE, TYPE_BAD, 2, 0, AllOnes, AllOnes));
    pending_reqs.push_back(mk(KIND_PURGE, TYPE_READ, AllOnes, AllOnes, 0, 0));
    pending_reqs.push_back(mk(KIND_SET, TYPE_UNLOCK, 1, 1, 0, 0));
    pending_reqs.push_back(mk(KIND_PURGE, TYPE_READ, 4, 0, 0, 0));
    for (int i = 0; i < 1400; i++) pending_reqs.push_back(random_req());

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 200) @(posedge clk);
    calm = 1'b1;
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Ran %0d lock requests: %0d ok, %0d conflict, %0d invalid, %0d full.",
             n_ok + n_conflict + n_invalid + n_full, n_ok, n_conflict, n_invalid, n_full);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
